@@ rtl/sstf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSTF scheduler package
// Shared constants, codes, state type and control bundles for the
// shortest-seek-time-first disk request scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

    localparam int QUEUE_DEPTH_DEF    = 16;
    localparam int TRACK_BITS_DEF     = 10;
    localparam int REQUESTER_BITS_DEF = 6;

    localparam int LIMIT_W     = 5;
    localparam int ACTIVE_W    = 6;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;
    localparam int KIND_W      = 2;

    localparam logic [KIND_W-1:0] KIND_ACCEPT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REFUSE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SERVICE = 2'd2;

    localparam logic ACTION_REQUEST = 1'b0;
    localparam logic ACTION_FINISH  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_QUEUE_LIMIT     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REQUESTER_TOTAL = 2'd1;

    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 5'd16;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 6'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SERVE
    } t_state;

    typedef struct packed {
        logic push;
        logic pop;
    } t_queue_op;

    typedef struct packed {
        logic step;
        logic clear;
    } t_seek_op;

endpackage

@@ rtl/sstf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSTF request queue
// Pending request store: valid bits, requester, track and arrival rank per
// slot, with a fill count. One scan read port, push to lowest free slot,
// pop with rank compaction.
// ----------------------------------------------------------------------------
module sstf_queue #(
    parameter int QUEUE_DEPTH    = sstf_pkg::QUEUE_DEPTH_DEF,
    parameter int TRACK_BITS     = sstf_pkg::TRACK_BITS_DEF,
    parameter int REQUESTER_BITS = sstf_pkg::REQUESTER_BITS_DEF,
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sstf_pkg::t_queue_op       i_op,
    input  logic [REQUESTER_BITS-1:0] i_push_requester,
    input  logic [TRACK_BITS-1:0]     i_push_track,
    input  logic [IDX_W-1:0]          i_pop_idx,
    input  logic [IDX_W-1:0]          i_pop_age,
    input  logic [IDX_W-1:0]          i_rd_idx,
    output logic                      o_rd_valid,
    output logic [REQUESTER_BITS-1:0] o_rd_requester,
    output logic [TRACK_BITS-1:0]     o_rd_track,
    output logic [IDX_W-1:0]          o_rd_age,
    output logic [CNT_W-1:0]          o_count
);

    logic [QUEUE_DEPTH-1:0]    r_valid;
    logic [REQUESTER_BITS-1:0] r_requester [QUEUE_DEPTH];
    logic [TRACK_BITS-1:0]     r_track     [QUEUE_DEPTH];
    logic [IDX_W-1:0]          r_age       [QUEUE_DEPTH];
    logic [CNT_W-1:0]          r_count;
    logic [IDX_W-1:0]          free_slot;

    always_comb begin
        free_slot = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_slot = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_op.push) begin
            r_valid[free_slot] <= 1'b1;
            r_count            <= r_count + 1'b1;
        end else if (i_op.pop) begin
            r_valid[i_pop_idx] <= 1'b0;
            r_count            <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_requester[free_slot] <= i_push_requester;
            r_track[free_slot]     <= i_push_track;
            r_age[free_slot]       <= r_count[IDX_W-1:0];
        end else if (i_op.pop) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (r_valid[i] && (r_age[i] > i_pop_age)) begin
                    r_age[i] <= r_age[i] - 1'b1;
                end
            end
        end
    end

    assign o_rd_valid     = r_valid[i_rd_idx];
    assign o_rd_requester = r_requester[i_rd_idx];
    assign o_rd_track     = r_track[i_rd_idx];
    assign o_rd_age       = r_age[i_rd_idx];
    assign o_count        = r_count;

endmodule

@@ rtl/sstf_seek_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSTF seek unit
// Shared distance comparator: one entry per step, keeps the nearest entry
// to the head so far, oldest first on equal distance.
// ----------------------------------------------------------------------------
module sstf_seek_unit #(
    parameter int QUEUE_DEPTH    = sstf_pkg::QUEUE_DEPTH_DEF,
    parameter int TRACK_BITS     = sstf_pkg::TRACK_BITS_DEF,
    parameter int REQUESTER_BITS = sstf_pkg::REQUESTER_BITS_DEF,
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sstf_pkg::t_seek_op        i_op,
    input  logic [TRACK_BITS-1:0]     i_head,
    input  logic [IDX_W-1:0]          i_idx,
    input  logic                      i_valid,
    input  logic [TRACK_BITS-1:0]     i_track,
    input  logic [REQUESTER_BITS-1:0] i_requester,
    input  logic [IDX_W-1:0]          i_age,
    output logic [IDX_W-1:0]          o_idx,
    output logic [IDX_W-1:0]          o_age,
    output logic [TRACK_BITS-1:0]     o_track,
    output logic [REQUESTER_BITS-1:0] o_requester
);

    logic                      r_found;
    logic [TRACK_BITS-1:0]     r_dist;
    logic [IDX_W-1:0]          r_idx;
    logic [IDX_W-1:0]          r_age;
    logic [TRACK_BITS-1:0]     r_track;
    logic [REQUESTER_BITS-1:0] r_requester;
    logic [TRACK_BITS-1:0]     seek_dist;
    logic                      take;

    always_comb begin
        seek_dist = (i_track >= i_head) ? (i_track - i_head) : (i_head - i_track);
        take = i_valid && (i_op.clear || !r_found || (seek_dist < r_dist) ||
                           ((seek_dist == r_dist) && (i_age < r_age)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_op.step) begin
            r_found <= i_op.clear ? take : (r_found | take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.step && take) begin
            r_dist      <= seek_dist;
            r_idx       <= i_idx;
            r_age       <= i_age;
            r_track     <= i_track;
            r_requester <= i_requester;
        end
    end

    assign o_idx       = r_idx;
    assign o_age       = r_age;
    assign o_track     = r_track;
    assign o_requester = r_requester;

endmodule

@@ rtl/sstf_disk_request_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSTF disk request scheduler
// Bounded queue of disk requests served nearest-track-first from the head
// position, oldest first on equal distance.
//
//   Channel   Handshake                  Beat
//   -------   ------------------------   ------------------------------------
//   item in   start & !busy              i_action, i_requester, i_track
//   result    o_result_valid (1 cycle)   o_kind, o_served_requester,
//                                        o_served_track, o_last
//   config    i_cfg_valid & o_cfg_ready  i_cfg_index, i_cfg_data
//
// A request beat's accept or refuse result is registered and shown in the cycle
// after start. Each service scans every queue slot in turn through the single
// distance comparator, then pops the nearest entry and emits its result.
// Synchronous active-low reset clears the queue, sets the head to track 0 and
// loads the register defaults. Results cannot be stalled; busy drops in the
// same cycle as the last service result is shown.
// ----------------------------------------------------------------------------
module sstf_disk_request_scheduler #(
    parameter int QUEUE_DEPTH    = sstf_pkg::QUEUE_DEPTH_DEF,
    parameter int TRACK_BITS     = sstf_pkg::TRACK_BITS_DEF,
    parameter int REQUESTER_BITS = sstf_pkg::REQUESTER_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_action,
    input  logic [REQUESTER_BITS-1:0]        i_requester,
    input  logic [TRACK_BITS-1:0]            i_track,
    output logic                             o_result_valid,
    output logic [sstf_pkg::KIND_W-1:0]      o_kind,
    output logic [REQUESTER_BITS-1:0]        o_served_requester,
    output logic [TRACK_BITS-1:0]            o_served_track,
    output logic                             o_last,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sstf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [sstf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > sstf_pkg::ACTIVE_W) ? CNT_W : sstf_pkg::ACTIVE_W;

    sstf_pkg::t_state                r_state, n_state;
    logic [IDX_W-1:0]                r_scan_idx, n_scan_idx;
    logic [TRACK_BITS-1:0]           r_head, n_head;
    logic [sstf_pkg::ACTIVE_W-1:0]   r_active, n_active;
    logic [sstf_pkg::LIMIT_W-1:0]    r_limit, n_limit;
    logic                            r_out_valid, n_out_valid;
    logic [sstf_pkg::KIND_W-1:0]     r_out_kind, n_out_kind;
    logic [REQUESTER_BITS-1:0]       r_out_requester, n_out_requester;
    logic [TRACK_BITS-1:0]           r_out_track, n_out_track;
    logic                            r_out_last, n_out_last;

    sstf_pkg::t_queue_op             q_op;
    sstf_pkg::t_seek_op              s_op;
    logic                            q_rd_valid;
    logic [REQUESTER_BITS-1:0]       q_rd_requester;
    logic [TRACK_BITS-1:0]           q_rd_track;
    logic [IDX_W-1:0]                q_rd_age;
    logic [CNT_W-1:0]                q_count;
    logic [IDX_W-1:0]                best_idx;
    logic [IDX_W-1:0]                best_age;
    logic [TRACK_BITS-1:0]           best_track;
    logic [REQUESTER_BITS-1:0]       best_requester;

    logic [CMP_W-1:0]                lim_ext;
    logic [CMP_W-1:0]                eff_limit;
    logic [CMP_W-1:0]                count_ext;
    logic [CMP_W-1:0]                count_after;
    logic [sstf_pkg::ACTIVE_W-1:0]   active_dec;
    logic [sstf_pkg::ACTIVE_W-1:0]   active_after;
    logic                            full;
    logic                            is_request;
    logic                            serve_idle;
    logic                            serve_next;

    function automatic logic serve_due(input logic [CMP_W-1:0] count,
                                       input logic [CMP_W-1:0] limit,
                                       input logic [sstf_pkg::ACTIVE_W-1:0] active);
        logic [CMP_W-1:0] act_ext;
        logic [CMP_W-1:0] need;
        act_ext   = CMP_W'(active);
        need      = (limit < act_ext) ? limit : act_ext;
        serve_due = (count != '0) && (count >= need);
    endfunction

    sstf_queue #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .TRACK_BITS     (TRACK_BITS),
        .REQUESTER_BITS (REQUESTER_BITS)
    ) u_queue (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (q_op),
        .i_push_requester (i_requester),
        .i_push_track     (i_track),
        .i_pop_idx        (best_idx),
        .i_pop_age        (best_age),
        .i_rd_idx         (r_scan_idx),
        .o_rd_valid       (q_rd_valid),
        .o_rd_requester   (q_rd_requester),
        .o_rd_track       (q_rd_track),
        .o_rd_age         (q_rd_age),
        .o_count          (q_count)
    );

    sstf_seek_unit #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .TRACK_BITS     (TRACK_BITS),
        .REQUESTER_BITS (REQUESTER_BITS)
    ) u_seek (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (s_op),
        .i_head      (r_head),
        .i_idx       (r_scan_idx),
        .i_valid     (q_rd_valid),
        .i_track     (q_rd_track),
        .i_requester (q_rd_requester),
        .i_age       (q_rd_age),
        .o_idx       (best_idx),
        .o_age       (best_age),
        .o_track     (best_track),
        .o_requester (best_requester)
    );

    always_comb begin
        lim_ext      = CMP_W'(r_limit);
        eff_limit    = (lim_ext == '0) ? CMP_W'(1) :
                       (lim_ext > CMP_W'(QUEUE_DEPTH)) ? CMP_W'(QUEUE_DEPTH) : lim_ext;
        count_ext    = CMP_W'(q_count);
        full         = (count_ext >= eff_limit);
        is_request   = (i_action == sstf_pkg::ACTION_REQUEST);
        active_dec   = (r_active != '0) ? (r_active - 1'b1) : r_active;
        active_after = is_request ? r_active : active_dec;
        count_after  = (is_request && !full) ? (count_ext + 1'b1) : count_ext;
        serve_idle   = serve_due(count_after, eff_limit, active_after);
        serve_next   = serve_due(count_ext - 1'b1, eff_limit, r_active);
    end

    always_comb begin
        n_state         = r_state;
        n_scan_idx      = r_scan_idx;
        n_head          = r_head;
        n_active        = r_active;
        n_limit         = r_limit;
        n_out_valid     = 1'b0;
        n_out_kind      = r_out_kind;
        n_out_requester = r_out_requester;
        n_out_track     = r_out_track;
        n_out_last      = r_out_last;
        q_op            = '0;
        s_op            = '0;

        unique case (r_state)
            sstf_pkg::ST_IDLE: begin
                if (start) begin
                    if (is_request) begin
                        n_out_valid     = 1'b1;
                        n_out_kind      = full ? sstf_pkg::KIND_REFUSE
                                               : sstf_pkg::KIND_ACCEPT;
                        n_out_requester = i_requester;
                        n_out_track     = i_track;
                        n_out_last      = !serve_idle;
                        q_op.push       = !full;
                    end else begin
                        n_active = active_dec;
                    end
                    if (serve_idle) begin
                        n_state    = sstf_pkg::ST_SCAN;
                        n_scan_idx = '0;
                    end
                end
            end
            sstf_pkg::ST_SCAN: begin
                s_op.step  = 1'b1;
                s_op.clear = (r_scan_idx == '0);
                if (r_scan_idx == IDX_W'(QUEUE_DEPTH - 1)) begin
                    n_state = sstf_pkg::ST_SERVE;
                end else begin
                    n_scan_idx = r_scan_idx + 1'b1;
                end
            end
            sstf_pkg::ST_SERVE: begin
                n_out_valid     = 1'b1;
                n_out_kind      = sstf_pkg::KIND_SERVICE;
                n_out_requester = best_requester;
                n_out_track     = best_track;
                n_out_last      = !serve_next;
                q_op.pop        = 1'b1;
                n_head          = best_track;
                n_scan_idx      = '0;
                n_state         = serve_next ? sstf_pkg::ST_SCAN : sstf_pkg::ST_IDLE;
            end
            default: begin
                n_state = sstf_pkg::ST_IDLE;
            end
        endcase

        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                sstf_pkg::CFG_QUEUE_LIMIT: begin
                    n_limit = i_cfg_data[sstf_pkg::LIMIT_W-1:0];
                end
                sstf_pkg::CFG_REQUESTER_TOTAL: begin
                    n_active = i_cfg_data[sstf_pkg::ACTIVE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sstf_pkg::ST_IDLE;
            r_head      <= '0;
            r_active    <= sstf_pkg::ACTIVE_RESET;
            r_limit     <= sstf_pkg::LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_active    <= n_active;
            r_limit     <= n_limit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_idx      <= n_scan_idx;
        r_out_kind      <= n_out_kind;
        r_out_requester <= n_out_requester;
        r_out_track     <= n_out_track;
        r_out_last      <= n_out_last;
    end

    assign busy               = (r_state != sstf_pkg::ST_IDLE);
    assign o_cfg_ready        = !busy;
    assign o_result_valid     = r_out_valid;
    assign o_kind             = r_out_kind;
    assign o_served_requester = r_out_requester;
    assign o_served_track     = r_out_track;
    assign o_last             = r_out_last;

endmodule
